### sv/rcfu_pkg.sv
// ----------------------------------------------------------------------------
// rcfu_pkg
// Shared types and constants for the rc link channel frame unpacker.
// ----------------------------------------------------------------------------
package rcfu_pkg;

  localparam int unsigned MaxFrame     = 64;
  localparam int unsigned AddrW        = $clog2(MaxFrame);
  localparam int unsigned PosW         = 7;
  localparam int unsigned ChanBits     = 11;
  localparam int unsigned ChanCount    = 16;
  localparam int unsigned PayloadStart = 3;
  localparam int unsigned MinChanFrame = 25;
  localparam int unsigned BufW         = ChanBits - 1 + 8;
  localparam int unsigned CntW         = $clog2(BufW + 1);
  localparam int unsigned PaddrW       = 4;

  localparam logic [7:0] SyncReset     = 8'hC8;
  localparam logic [7:0] ChanTypeReset = 8'h16;
  localparam logic [6:0] MaxLenReset   = 7'd64;

  typedef enum logic [1:0] {
    REG_SYNC     = 2'd0,
    REG_CHAN_TYP = 2'd1,
    REG_MAX_LEN  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] sync_value;
    logic [7:0] channel_frame_type;
    logic [6:0] max_frame_length;
  } cfg_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EMIT = 1'b1
  } state_t;

endpackage

### sv/rcfu_cfg_regs.sv
// ----------------------------------------------------------------------------
// rcfu_cfg_regs
// Configuration register file behind a simple APB-style slave port.
// ----------------------------------------------------------------------------
module rcfu_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rcfu_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output rcfu_pkg::cfg_t              cfg
);

  rcfu_pkg::cfg_t cfg_r;
  rcfu_pkg::cfg_t cfg_nxt;
  logic           wr_en;
  logic [1:0]     reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[3:2];
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    prdata  = 32'd0;
    unique case (reg_sel)
      rcfu_pkg::REG_SYNC: begin
        prdata = {24'd0, cfg_r.sync_value};
        if (wr_en) cfg_nxt.sync_value = pwdata[7:0];
      end
      rcfu_pkg::REG_CHAN_TYP: begin
        prdata = {24'd0, cfg_r.channel_frame_type};
        if (wr_en) cfg_nxt.channel_frame_type = pwdata[7:0];
      end
      rcfu_pkg::REG_MAX_LEN: begin
        prdata = {25'd0, cfg_r.max_frame_length};
        if (wr_en) cfg_nxt.max_frame_length = pwdata[6:0];
      end
      default: begin
        prdata = 32'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_value         <= rcfu_pkg::SyncReset;
      cfg_r.channel_frame_type <= rcfu_pkg::ChanTypeReset;
      cfg_r.max_frame_length   <= rcfu_pkg::MaxLenReset;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### sv/rc_link_frame_channel_unpacker_unit.sv
// ----------------------------------------------------------------------------
// rc_link_frame_channel_unpacker_unit
// Frame parser for a serial remote-control link: unpacks 16 channel values.
// ----------------------------------------------------------------------------
// Usage:
//   in_* carries one received byte per transfer. The parser hunts for the
//   sync byte, takes the length byte, and writes frame bytes into a 64-entry
//   frame memory. In the byte-collecting phase in_stall stays low and
//   every input transfer is taken.
//   When a complete channels frame (type match, at least 25 bytes) ends, the
//   unpacker streams payload bytes 3..24 out of the frame memory, one read
//   per byte through a registered read port, via an 18-bit bit buffer, and
//   presents 16 channel transfers on out_*. Each of the 22 byte reads is
//   followed by a step that appends the byte to the buffer; a channel is
//   sent once 11 bits are buffered and the output register is free. in_stall
//   is high until the sixteenth channel is registered.
//   out_* sits behind an output register: while out_stall is high the
//   result holds and no further channel is sent; once the sixteenth channel
//   is in the register, input transfers are taken again even if it still waits.
//   Reset (rst_n low, synchronous) returns to sync hunting, drops any
//   pending result and loads the register reset values; frame memory
//   contents are left as they are.
//   Registers at byte addresses 0, 4, 8: sync value, channel frame type,
//   maximum frame length.
// ----------------------------------------------------------------------------
module rc_link_frame_channel_unpacker_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_rx_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [3:0]                  out_channel_index,
  output logic [10:0]                 out_channel_value,
  output logic                        out_last_channel,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rcfu_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int unsigned AW = rcfu_pkg::AddrW;
  localparam int unsigned PW = rcfu_pkg::PosW;
  localparam int unsigned BW = rcfu_pkg::BufW;
  localparam int unsigned CW = rcfu_pkg::CntW;

  rcfu_pkg::cfg_t   cfg;
  rcfu_pkg::state_t state_r, state_nxt;

  logic [PW-1:0] pos_r, pos_nxt;
  logic [PW-1:0] total_r, total_nxt;
  logic [7:0]    type_r, type_nxt;

  logic [7:0]    frame_mem [rcfu_pkg::MaxFrame];
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic          mem_re;
  logic [7:0]    mem_rdata_r;

  logic [AW-1:0] rd_addr_r, rd_addr_nxt;
  logic          pend_r, pend_nxt;
  logic [BW-1:0] buf_r, buf_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [3:0]    ch_r, ch_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [3:0]    out_idx_r, out_idx_nxt;
  logic [10:0]   out_val_r, out_val_nxt;
  logic          out_last_r, out_last_nxt;

  logic          in_acc;
  logic          slot_free;
  logic [PW-1:0] eff_max;
  logic [8:0]    len_total;
  logic          len_bad;
  logic [PW-1:0] pos_inc;

  rcfu_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign in_stall  = (state_r != rcfu_pkg::ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  assign out_valid         = out_valid_r;
  assign out_channel_index = out_idx_r;
  assign out_channel_value = out_val_r;
  assign out_last_channel  = out_last_r;

  assign eff_max   = (cfg.max_frame_length > PW'(rcfu_pkg::MaxFrame)) ?
                     PW'(rcfu_pkg::MaxFrame) : cfg.max_frame_length;
  assign len_total = {1'b0, in_rx_byte} + 9'd2;
  assign len_bad   = (in_rx_byte == 8'd0) || (in_rx_byte >= 8'd254) ||
                     (len_total > {2'b00, eff_max});
  assign pos_inc   = pos_r + PW'(1);

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    total_nxt     = total_r;
    type_nxt      = type_r;
    mem_we        = 1'b0;
    mem_wa        = pos_r[AW-1:0];
    mem_re        = 1'b0;
    rd_addr_nxt   = rd_addr_r;
    pend_nxt      = pend_r;
    buf_nxt       = buf_r;
    cnt_nxt       = cnt_r;
    ch_nxt        = ch_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_idx_nxt   = out_idx_r;
    out_val_nxt   = out_val_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      rcfu_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (pos_r == PW'(0)) begin
            if (in_rx_byte == cfg.sync_value) begin
              mem_we  = 1'b1;
              pos_nxt = PW'(1);
            end
          end else if (pos_r == PW'(1)) begin
            mem_we = 1'b1;
            if (len_bad) begin
              pos_nxt   = PW'(0);
              total_nxt = PW'(0);
            end else begin
              total_nxt = len_total[PW-1:0];
              pos_nxt   = PW'(2);
            end
          end else if (pos_r >= PW'(rcfu_pkg::MaxFrame) || pos_r >= total_r) begin
            pos_nxt = PW'(0);
          end else begin
            mem_we  = 1'b1;
            pos_nxt = pos_inc;
            if (pos_r == PW'(2)) type_nxt = in_rx_byte;
            if (pos_inc == total_r) begin
              pos_nxt = PW'(0);
              // type byte may be arriving right now for a 3-byte frame
              if (total_r >= PW'(rcfu_pkg::MinChanFrame) &&
                  type_r == cfg.channel_frame_type) begin
                state_nxt   = rcfu_pkg::ST_EMIT;
                rd_addr_nxt = AW'(rcfu_pkg::PayloadStart);
                pend_nxt    = 1'b0;
                buf_nxt     = '0;
                cnt_nxt     = '0;
                ch_nxt      = '0;
              end
            end
          end
        end
      end
      rcfu_pkg::ST_EMIT: begin
        if (pend_r) begin
          // read data lands: append above the bits already buffered
          buf_nxt  = buf_r | (BW'(mem_rdata_r) << cnt_r);
          cnt_nxt  = cnt_r + CW'(8);
          pend_nxt = 1'b0;
        end else if (cnt_r >= CW'(rcfu_pkg::ChanBits)) begin
          if (slot_free) begin
            out_valid_nxt = 1'b1;
            out_idx_nxt   = ch_r;
            out_val_nxt   = buf_r[10:0];
            out_last_nxt  = (ch_r == 4'(rcfu_pkg::ChanCount - 1));
            buf_nxt       = buf_r >> rcfu_pkg::ChanBits;
            cnt_nxt       = cnt_r - CW'(rcfu_pkg::ChanBits);
            ch_nxt        = ch_r + 4'd1;
            if (ch_r == 4'(rcfu_pkg::ChanCount - 1)) state_nxt = rcfu_pkg::ST_IDLE;
          end
        end else begin
          mem_re      = 1'b1;
          pend_nxt    = 1'b1;
          rd_addr_nxt = rd_addr_r + AW'(1);
        end
      end
      default: begin
        state_nxt = rcfu_pkg::ST_IDLE;
      end
    endcase
  end

  // frame memory: one write port for incoming bytes, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) frame_mem[mem_wa] <= in_rx_byte;
    if (mem_re) mem_rdata_r <= frame_mem[rd_addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rcfu_pkg::ST_IDLE;
      pos_r       <= '0;
      total_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      total_r     <= total_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    type_r     <= type_nxt;
    rd_addr_r  <= rd_addr_nxt;
    buf_r      <= buf_nxt;
    cnt_r      <= cnt_nxt;
    ch_r       <= ch_nxt;
    out_idx_r  <= out_idx_nxt;
    out_val_r  <= out_val_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule
